// ===== src/dnsr_pkg.sv =====
// Package for the DNS A-query responder: payload structs, parse phase codes,
// header rewrite and answer record byte functions. No dependencies.
package dnsr_pkg;

    localparam int HEADER_BYTES = 12;
    localparam int ANSWER_BYTES = 16;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ANSWER_ADDRESS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANSWER_TTL     = 1'b1;

    localparam logic [31:0] ANSWER_ADDRESS_RESET = 32'hC0A8_0164;
    localparam logic [31:0] ANSWER_TTL_RESET     = 32'd300;

    localparam logic [3:0] HDR_FLAGS_HI   = 4'd2;
    localparam logic [3:0] HDR_FLAGS_LO   = 4'd3;
    localparam logic [3:0] HDR_ANCOUNT_HI = 4'd6;
    localparam logic [3:0] HDR_ANCOUNT_LO = 4'd7;
    localparam logic [3:0] HDR_LAST       = 4'(HEADER_BYTES - 1);

    typedef enum logic [2:0] {
        PH_HEADER   = 3'd0,
        PH_NAME     = 3'd1,
        PH_TYPE_HI  = 3'd2,
        PH_TYPE_LO  = 3'd3,
        PH_CLASS_HI = 3'd4,
        PH_CLASS_LO = 3'd5,
        PH_SWALLOW  = 3'd6
    } phase_t;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       packet_end;
    } query_t;

    typedef struct packed {
        logic [7:0] response_byte;
        logic       response_end;
        logic       response_send;
    } response_t;

    // Flags become 0x8180, answer count becomes 1.
    function automatic logic [7:0] header_rewrite(input logic [3:0] pos,
                                                  input logic [7:0] b);
        logic [7:0] r;
        begin
            case (pos)
                HDR_FLAGS_HI:   r = 8'h81;
                HDR_FLAGS_LO:   r = 8'h80;
                HDR_ANCOUNT_HI: r = 8'h00;
                HDR_ANCOUNT_LO: r = 8'h01;
                default:        r = b;
            endcase
            return r;
        end
    endfunction

    // Answer record: ptr C00C, type A, class IN, TTL, rdlength 4, address.
    function automatic logic [7:0] answer_byte(input logic [3:0]  idx,
                                               input logic [31:0] ttl,
                                               input logic [31:0] addr);
        logic [7:0] r;
        begin
            case (idx)
                4'd0:    r = 8'hC0;
                4'd1:    r = 8'h0C;
                4'd2:    r = 8'h00;
                4'd3:    r = 8'h01;
                4'd4:    r = 8'h00;
                4'd5:    r = 8'h01;
                4'd6:    r = ttl[31:24];
                4'd7:    r = ttl[23:16];
                4'd8:    r = ttl[15:8];
                4'd9:    r = ttl[7:0];
                4'd10:   r = 8'h00;
                4'd11:   r = 8'h04;
                4'd12:   r = addr[31:24];
                4'd13:   r = addr[23:16];
                4'd14:   r = addr[15:8];
                default: r = addr[7:0];
            endcase
            return r;
        end
    endfunction

endpackage

// ===== src/dns_a_query_responder.sv =====
// DNS A-query responder top level: byte-stream parser with one output register.
// Depends on dnsr_pkg.
//
// A response byte is registered in the output register in the cycle after its
// query byte is accepted. One byte per cycle while response_stall does not
// hold the output; an A query adds a 16-byte answer burst from the answer
// counter, during which query is stalled. Reset (async, active low) clears
// parse state and output valid and loads the default answer address and TTL.
module dns_a_query_responder (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         query_valid,
    output logic                         query_stall,
    input  dnsr_pkg::query_t             query,
    output logic                         response_valid,
    input  logic                         response_stall,
    output dnsr_pkg::response_t          response,
    input  logic                         cfg_write,
    input  logic [dnsr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dnsr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import dnsr_pkg::*;

    localparam int CNT_W = $clog2(ANSWER_BYTES + 1);

    logic [31:0]      answer_address_reg;
    logic [31:0]      answer_ttl_reg;
    phase_t           phase_reg, phase_next;
    logic [3:0]       hdr_pos_reg, hdr_pos_next;
    logic [7:0]       type_hi_reg, type_hi_next;
    logic             type_a_reg, type_a_next;
    logic [CNT_W-1:0] burst_cnt_reg, burst_cnt_next;
    logic             out_valid_reg, out_valid_next;
    response_t        out_reg, out_next;

    logic             load;
    logic             accept;
    logic             burst_active;
    logic             has_out;
    response_t        item_out;
    logic [3:0]       ans_idx;

    assign burst_active = (burst_cnt_reg != '0);
    assign load         = !out_valid_reg || !response_stall;
    assign query_stall  = burst_active || !load;
    assign accept       = query_valid && !query_stall;
    assign ans_idx      = 4'(CNT_W'(ANSWER_BYTES) - burst_cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            answer_address_reg <= ANSWER_ADDRESS_RESET;
            answer_ttl_reg     <= ANSWER_TTL_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_ANSWER_ADDRESS: answer_address_reg <= cfg_data;
                CFG_ANSWER_TTL:     answer_ttl_reg     <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Parse one query byte.
    always_comb
    begin
        phase_next     = phase_reg;
        hdr_pos_next   = hdr_pos_reg;
        type_hi_next   = type_hi_reg;
        type_a_next    = type_a_reg;
        burst_cnt_next = burst_cnt_reg;
        has_out        = 1'b1;
        item_out.response_byte = query.packet_byte;
        item_out.response_end  = query.packet_end;
        item_out.response_send = 1'b0;

        case (phase_reg)
            PH_HEADER:
            begin
                item_out.response_byte = header_rewrite(hdr_pos_reg, query.packet_byte);
                if (hdr_pos_reg >= HDR_LAST)
                begin
                    hdr_pos_next = '0;
                    phase_next   = PH_NAME;
                end
                else
                    hdr_pos_next = hdr_pos_reg + 4'd1;
            end
            PH_NAME:
                if (query.packet_byte == 8'd0)
                    phase_next = PH_TYPE_HI;
            PH_TYPE_HI:
            begin
                type_hi_next = query.packet_byte;
                phase_next   = PH_TYPE_LO;
            end
            PH_TYPE_LO:
            begin
                type_a_next = (type_hi_reg == 8'd0) && (query.packet_byte == 8'd1);
                phase_next  = PH_CLASS_HI;
            end
            PH_CLASS_HI:
                phase_next = PH_CLASS_LO;
            PH_CLASS_LO:
            begin
                hdr_pos_next          = '0;
                phase_next            = PH_SWALLOW;
                item_out.response_end = !type_a_reg;
                if (type_a_reg)
                    burst_cnt_next = CNT_W'(ANSWER_BYTES);
            end
            default:
            begin
                has_out = 1'b0;
            end
        endcase

        // Packet end always returns to the header phase; early end drops.
        if (query.packet_end)
        begin
            hdr_pos_next = '0;
            phase_next   = PH_HEADER;
        end

        if (!accept)
        begin
            phase_next     = phase_reg;
            hdr_pos_next   = hdr_pos_reg;
            type_hi_next   = type_hi_reg;
            type_a_next    = type_a_reg;
            burst_cnt_next = burst_cnt_reg;
        end

        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (load)
        begin
            out_valid_next = 1'b0;
            if (burst_active)
            begin
                out_valid_next         = 1'b1;
                out_next.response_byte = answer_byte(ans_idx, answer_ttl_reg,
                                                     answer_address_reg);
                out_next.response_end  = (burst_cnt_reg == CNT_W'(1));
                out_next.response_send = (burst_cnt_reg == CNT_W'(1));
                burst_cnt_next         = burst_cnt_reg - CNT_W'(1);
            end
            else if (accept && has_out)
            begin
                out_valid_next = 1'b1;
                out_next       = item_out;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            hdr_pos_reg   <= '0;
            type_hi_reg   <= '0;
            type_a_reg    <= 1'b0;
            burst_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            hdr_pos_reg   <= hdr_pos_next;
            type_hi_reg   <= type_hi_next;
            type_a_reg    <= type_a_next;
            burst_cnt_reg <= burst_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign response_valid = out_valid_reg;
    assign response       = out_reg;

    // Query side must be held off for the whole answer burst.
    a_burst_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        burst_active |-> query_stall)
        else $error("query accepted during answer burst");

    // Send is only meaningful on the final byte.
    a_send_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        (response_valid && response.response_send) |-> response.response_end)
        else $error("response_send without response_end");

    // Last burst byte closes the response with send.
    a_burst_close: assert property (@(posedge clk) disable iff (!rst_n)
        (burst_cnt_reg == CNT_W'(1) && load) |=>
            (response_valid && response.response_end && response.response_send))
        else $error("answer burst did not close the response");

    // Burst only starts after the last class byte.
    a_burst_phase: assert property (@(posedge clk) disable iff (!rst_n)
        burst_active |-> (phase_reg == PH_SWALLOW || phase_reg == PH_HEADER))
        else $error("answer burst in unexpected parse phase");

    // A burst starts only with a non-final response byte in the output register.
    a_burst_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(burst_active) |-> (response_valid && !response.response_end))
        else $error("answer burst without echoed class byte");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for dns_a_query_responder: directed and random DNS queries,
// random idling on both channels, and a long receiver hold-off.
// Depends on dnsr_pkg and the responder RTL.
`timescale 1ns / 1ps

module tb_top;
    import dnsr_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 4;
    localparam int HOLD_CYCLES = 150;

    logic                  clk;
    logic                  rst_n;
    logic                  query_valid;
    logic                  query_stall;
    query_t                query;
    logic                  response_valid;
    logic                  response_stall;
    response_t             response;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    dns_a_query_responder dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .query_valid    (query_valid),
        .query_stall    (query_stall),
        .query          (query),
        .response_valid (response_valid),
        .response_stall (response_stall),
        .response       (response),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // Predicted parser state and answer registers
    phase_t      prs_phase   = PH_HEADER;
    logic [3:0]  prs_hdr_pos = '0;
    logic [7:0]  prs_type_hi = '0;
    logic        prs_type_a  = 1'b0;
    logic [31:0] ans_addr    = ANSWER_ADDRESS_RESET;
    logic [31:0] ans_ttl     = ANSWER_TTL_RESET;

    response_t   expected_responses[$];
    query_t      pkt_bytes[$];

    int          err_count     = 0;
    int          cycle_count   = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int          hold_cycles   = 0;
    // toggled by the test to request a hold-off; the receiver tracks what it has seen
    bit          hold_req      = 1'b0;
    bit          hold_seen     = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Expected response bytes for one accepted query byte
    task automatic predict_response_bytes(input query_t q);
        logic [7:0]   b;
        logic [7:0]   echo;
        logic [127:0] answer;
        phase_t       nxt;
        bit           done;
        begin
            b    = q.packet_byte;
            echo = b;
            nxt  = prs_phase;
            done = 1'b0;
            case (prs_phase)
                PH_HEADER:
                begin
                    case (prs_hdr_pos)
                        HDR_FLAGS_HI:   echo = 8'h81;
                        HDR_FLAGS_LO:   echo = 8'h80;
                        HDR_ANCOUNT_HI: echo = 8'h00;
                        HDR_ANCOUNT_LO: echo = 8'h01;
                        default:        echo = b;
                    endcase
                    if (prs_hdr_pos >= HDR_LAST)
                    begin
                        prs_hdr_pos = '0;
                        nxt = PH_NAME;
                    end
                    else
                        prs_hdr_pos = prs_hdr_pos + 4'd1;
                end
                PH_NAME:
                    if (b == 8'h00)
                        nxt = PH_TYPE_HI;
                PH_TYPE_HI:
                begin
                    prs_type_hi = b;
                    nxt = PH_TYPE_LO;
                end
                PH_TYPE_LO:
                begin
                    prs_type_a = (prs_type_hi == 8'h00) && (b == 8'h01);
                    nxt = PH_CLASS_HI;
                end
                PH_CLASS_HI:
                    nxt = PH_CLASS_LO;
                PH_CLASS_LO:
                begin
                    done = 1'b1;
                    if (prs_type_a)
                    begin
                        answer = {16'hC00C, 16'h0001, 16'h0001, ans_ttl, 16'h0004, ans_addr};
                        expected_responses.push_back({b, 1'b0, 1'b0});
                        for (int i = 0; i < ANSWER_BYTES; i++)
                            expected_responses.push_back({answer[127 - 8*i -: 8],
                                                          i == ANSWER_BYTES - 1,
                                                          i == ANSWER_BYTES - 1});
                    end
                    else
                        expected_responses.push_back({b, 1'b1, 1'b0});
                    prs_hdr_pos = '0;
                    prs_phase = q.packet_end ? PH_HEADER : PH_SWALLOW;
                end
                default:
                begin
                    // trailing bytes: no output, end of packet rearms the header
                    done = 1'b1;
                    if (q.packet_end)
                    begin
                        prs_hdr_pos = '0;
                        prs_phase = PH_HEADER;
                    end
                end
            endcase
            if (!done)
            begin
                if (q.packet_end)
                begin
                    // early end: echo with end set, drop, back to header
                    expected_responses.push_back({echo, 1'b1, 1'b0});
                    prs_hdr_pos = '0;
                    prs_phase = PH_HEADER;
                end
                else
                begin
                    expected_responses.push_back({echo, 1'b0, 1'b0});
                    prs_phase = nxt;
                end
            end
        end
    endtask

    // Response checking, then prediction for the query transaction at this edge
    always @(posedge clk)
    begin
        response_t want;
        if (rst_n)
        begin
            if (response_valid && !response_stall)
            begin
                if (expected_responses.size() == 0)
                begin
                    $error("unexpected response transaction: byte %h end %b send %b",
                           response.response_byte, response.response_end,
                           response.response_send);
                    err_count++;
                end
                else
                begin
                    want = expected_responses.pop_front();
                    if (response.response_byte !== want.response_byte)
                    begin
                        $error("response_byte: expected %h actual %h",
                               want.response_byte, response.response_byte);
                        err_count++;
                    end
                    if (response.response_end !== want.response_end)
                    begin
                        $error("response_end: expected %b actual %b",
                               want.response_end, response.response_end);
                        err_count++;
                    end
                    if (response.response_send !== want.response_send)
                    begin
                        $error("response_send: expected %b actual %b",
                               want.response_send, response.response_send);
                        err_count++;
                    end
                end
            end
            if (query_valid && !query_stall)
                predict_response_bytes(query);
            if (cfg_write)
            begin
                if (cfg_index == CFG_ANSWER_ADDRESS)
                    ans_addr = cfg_data;
                else if (cfg_index == CFG_ANSWER_TTL)
                    ans_ttl = cfg_data;
            end
        end
    end

    // Receiver: long hold-off when requested, random stalls otherwise
    always @(negedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen      <= hold_req;
            hold_cycles    <= HOLD_CYCLES - 1;
            response_stall <= 1'b1;
        end
        else if (hold_cycles > 0)
        begin
            response_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            response_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Offers one query transaction; valid stays high on return
    task automatic send_query(input query_t q);
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                @(negedge clk);
                query_valid = 1'b0;
            end
            @(negedge clk);
            query_valid = 1'b1;
            query = q;
            do
                @(posedge clk);
            while (query_stall);
        end
    endtask

    task automatic send_packet();
        begin
            foreach (pkt_bytes[i])
                send_query(pkt_bytes[i]);
        end
    endtask

    task automatic push_byte(input logic [7:0] b);
        begin
            pkt_bytes.push_back({b, 1'b0});
        end
    endtask

    task automatic mark_last();
        query_t q;
        begin
            q = pkt_bytes.pop_back();
            q.packet_end = 1'b1;
            pkt_bytes.push_back(q);
        end
    endtask

    // Random query; clean_a forces a complete A query with no trailer
    task automatic build_packet(input bit clean_a, output int useful);
        int          kind;
        int          name_len;
        int          trail;
        int          cut;
        int          pick;
        logic [15:0] qtype;
        begin
            pkt_bytes.delete();
            kind = clean_a ? 99 : $urandom_range(99);
            if (kind < 12)
            begin
                // noise: random bytes with plenty of zeros
                repeat ($urandom_range(1, 24))
                    push_byte(($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(255)));
                useful = pkt_bytes.size();
            end
            else
            begin
                repeat (HEADER_BYTES)
                    push_byte(8'($urandom_range(255)));
                if ($urandom_range(9) == 0)
                    name_len = $urandom_range(30, 70);
                else
                    name_len = $urandom_range(0, 12);
                repeat (name_len)
                    push_byte(8'($urandom_range(1, 255)));
                push_byte(8'h00);
                pick = $urandom_range(99);
                if (clean_a || pick < 50)
                    qtype = 16'h0001;
                else if (pick < 70)
                    qtype = {8'($urandom_range(1, 255)), 8'h01};
                else if (pick < 80)
                    qtype = {8'h00, 8'($urandom_range(255))};
                else
                    qtype = 16'($urandom_range(65535));
                push_byte(qtype[15:8]);
                push_byte(qtype[7:0]);
                if ($urandom_range(3) != 0)
                begin
                    push_byte(8'h00);
                    push_byte(8'h01);
                end
                else
                begin
                    push_byte(8'($urandom_range(255)));
                    push_byte(8'($urandom_range(255)));
                end
                useful = pkt_bytes.size();
                if (kind < 30)
                begin
                    // early end somewhere before the last class byte
                    cut = $urandom_range(0, useful - 2);
                    while (pkt_bytes.size() > cut + 1)
                        void'(pkt_bytes.pop_back());
                    useful = pkt_bytes.size();
                end
                else if (!clean_a && $urandom_range(1) == 1)
                begin
                    trail = $urandom_range(1, 6);
                    repeat (trail)
                        push_byte(8'($urandom_range(255)));
                end
            end
            mark_last();
        end
    endtask

    // Lower valid, wait for every expected byte, then let the pipeline drain
    task automatic wait_idle();
        begin
            @(negedge clk);
            query_valid = 1'b0;
            while (expected_responses.size() != 0)
                @(posedge clk);
            repeat (DRAIN_CYCLES)
                @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        begin
            @(negedge clk);
            cfg_write = 1'b1;
            cfg_index = idx;
            cfg_data  = value;
            @(negedge clk);
            cfg_write = 1'b0;
        end
    endtask

    // Minimal A query with reset answer registers, header bytes at both extremes
    task automatic test_reset_defaults();
        begin
            pkt_bytes.delete();
            for (int i = 0; i < HEADER_BYTES; i++)
                push_byte((i % 2 == 0) ? 8'hFF : 8'h00);
            push_byte(8'h00);
            push_byte(8'h00);
            push_byte(8'h01);
            push_byte(8'h00);
            push_byte(8'h01);
            mark_last();
            send_packet();
        end
    endtask

    // Packet ending on a rewritten flags byte, then a one-byte packet
    task automatic test_early_end();
        begin
            pkt_bytes.delete();
            push_byte(8'h00);
            push_byte(8'hFF);
            push_byte(8'hFF);
            mark_last();
            send_packet();
            pkt_bytes.delete();
            push_byte(8'hFF);
            mark_last();
            send_packet();
        end
    endtask

    task automatic test_random_traffic(input int target, input int unsigned s_pct,
                                       input int unsigned r_pct);
        int count;
        int useful;
        begin
            send_idle_pct = s_pct;
            recv_idle_pct = r_pct;
            count = 0;
            while (count < target)
            begin
                build_packet(1'b0, useful);
                send_packet();
                count += useful;
            end
        end
    endtask

    // Receiver holds off while A queries keep arriving, filling the block
    task automatic test_receiver_holdoff();
        int useful;
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
            build_packet(1'b1, useful);
            send_query(pkt_bytes.pop_front());
            hold_req = !hold_req;
            send_packet();
            repeat (2)
            begin
                build_packet(1'b1, useful);
                send_packet();
            end
        end
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        query_valid    = 1'b0;
        query          = '0;
        response_stall = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = CFG_ANSWER_ADDRESS;
        cfg_data       = '0;
        repeat (11)
            @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_early_end();
        wait_idle();

        write_reg(CFG_ANSWER_ADDRESS, 32'h0000_0000);
        write_reg(CFG_ANSWER_TTL, 32'hFFFF_FFFF);
        test_random_traffic(56, 16, 59);
        wait_idle();

        write_reg(CFG_ANSWER_ADDRESS, 32'hFFFF_FFFF);
        write_reg(CFG_ANSWER_TTL, 32'h0000_0000);
        test_random_traffic(56, 59, 16);
        wait_idle();

        test_receiver_holdoff();
        wait_idle();

        write_reg(CFG_ANSWER_ADDRESS, $urandom);
        write_reg(CFG_ANSWER_TTL, $urandom);
        test_random_traffic(56, 0, 0);
        wait_idle();

        if (expected_responses.size() != 0)
        begin
            $error("%0d expected response bytes never arrived", expected_responses.size());
            err_count++;
        end
        if (err_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
